// ----- src/irpd_pkg.sv -----
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and helpers for the pulse-distance IR decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int INTERVAL_W     = 16;
    localparam int FRAME_W        = 32;
    localparam int CFG_W          = 16;
    localparam int APB_DW         = 32;
    localparam int REG_IDX_W      = 3;
    localparam int APB_AW         = REG_IDX_W + 2;

    localparam logic [CFG_W-1:0] LEADER_MIN_RST = 16'd13000;
    localparam logic [CFG_W-1:0] LEADER_MAX_RST = 16'd14000;
    localparam logic [CFG_W-1:0] ONE_MIN_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] ONE_MAX_RST    = 16'd2400;
    localparam logic [CFG_W-1:0] ZERO_MIN_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] ZERO_MAX_RST   = 16'd1200;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEADER_MIN = 3'd0,
        REG_LEADER_MAX = 3'd1,
        REG_ONE_MIN    = 3'd2,
        REG_ONE_MAX    = 3'd3,
        REG_ZERO_MIN   = 3'd4,
        REG_ZERO_MAX   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] leader_min;
        logic [CFG_W-1:0] leader_max;
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] one_max;
        logic [CFG_W-1:0] zero_min;
        logic [CFG_W-1:0] zero_max;
    } irpd_cfg_t;

    function automatic logic in_window(
        input logic [INTERVAL_W-1:0] v,
        input logic [CFG_W-1:0]      lo,
        input logic [CFG_W-1:0]      hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

// ----- src/irpd_regs.sv -----
// ----------------------------------------------------------------------------
// irpd_regs
// APB register bank holding the leader, one and zero interval windows.
// ----------------------------------------------------------------------------
module irpd_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [irpd_pkg::APB_AW-1:0] paddr,
    input  logic [irpd_pkg::APB_DW-1:0] pwdata,
    output logic [irpd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output irpd_pkg::irpd_cfg_t        cfg
);
    import irpd_pkg::*;

    irpd_cfg_t        cfg_reg;
    reg_idx_t         idx;
    logic [CFG_W-1:0] rd_val;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_min <= LEADER_MIN_RST;
            cfg_reg.leader_max <= LEADER_MAX_RST;
            cfg_reg.one_min    <= ONE_MIN_RST;
            cfg_reg.one_max    <= ONE_MAX_RST;
            cfg_reg.zero_min   <= ZERO_MIN_RST;
            cfg_reg.zero_max   <= ZERO_MAX_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LEADER_MIN: cfg_reg.leader_min <= pwdata[CFG_W-1:0];
                REG_LEADER_MAX: cfg_reg.leader_max <= pwdata[CFG_W-1:0];
                REG_ONE_MIN:    cfg_reg.one_min    <= pwdata[CFG_W-1:0];
                REG_ONE_MAX:    cfg_reg.one_max    <= pwdata[CFG_W-1:0];
                REG_ZERO_MIN:   cfg_reg.zero_min   <= pwdata[CFG_W-1:0];
                REG_ZERO_MAX:   cfg_reg.zero_max   <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LEADER_MIN: rd_val = cfg_reg.leader_min;
            REG_LEADER_MAX: rd_val = cfg_reg.leader_max;
            REG_ONE_MIN:    rd_val = cfg_reg.one_min;
            REG_ONE_MAX:    rd_val = cfg_reg.one_max;
            REG_ZERO_MIN:   rd_val = cfg_reg.zero_min;
            REG_ZERO_MAX:   rd_val = cfg_reg.zero_max;
            default:        rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DW-CFG_W){1'b0}}, rd_val};

endmodule

// ----- src/irpd_core.sv -----
// ----------------------------------------------------------------------------
// irpd_core
// Interval classifier and frame assembler between an input and a result
// register.
// ----------------------------------------------------------------------------
module irpd_core #(
    parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  irpd_pkg::irpd_cfg_t            cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [irpd_pkg::INTERVAL_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irpd_pkg::FRAME_W-1:0]    m_tdata
);
    import irpd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam int IDX_W = $clog2(FRAME_BITS);

    logic                        in_valid_reg;
    logic [INTERVAL_W-1:0]       interval_reg;
    logic                        receiving_reg;
    logic                        receiving_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [FRAME_BITS-1:0]       shift_reg;
    logic [FRAME_BITS-1:0]       shift_next;
    logic [FRAME_BITS-1:0]       word;
    logic [FRAME_BITS+FRAME_W-1:0] word_ext;
    logic                        out_valid_reg;
    logic [FRAME_W-1:0]          out_data_reg;
    logic                        advance;
    logic                        emit;
    logic                        hit_one;
    logic                        hit_zero;
    logic                        hit_leader;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign hit_one    = in_window(interval_reg, cfg.one_min, cfg.one_max);
    assign hit_zero   = in_window(interval_reg, cfg.zero_min, cfg.zero_max);
    assign hit_leader = in_window(interval_reg, cfg.leader_min, cfg.leader_max);

    always_comb
    begin
        word                       = shift_reg;
        word[count_reg[IDX_W-1:0]] = hit_one;
        word_ext                   = {{FRAME_W{1'b0}}, word};
        receiving_next             = receiving_reg;
        count_next                 = count_reg;
        shift_next                 = shift_reg;
        emit                       = 1'b0;
        if (receiving_reg)
        begin
            if (hit_one || hit_zero)
            begin
                count_next = count_reg + 1'b1;
                shift_next = word;
                if (count_next == CNT_W'(FRAME_BITS))
                begin
                    emit           = 1'b1;
                    receiving_next = 1'b0;
                    count_next     = '0;
                    shift_next     = '0;
                end
            end
            else
            begin
                receiving_next = 1'b0;
                count_next     = '0;
                shift_next     = '0;
            end
        end
        if (hit_leader)
        begin
            receiving_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                receiving_reg <= receiving_next;
                count_reg     <= count_next;
                shift_reg     <= shift_next;
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            interval_reg <= s_tdata;
        end
        if (advance && emit)
        begin
            out_data_reg <= word_ext[FRAME_W-1:0];
        end
    end

endmodule

// ----- src/ir_pulse_distance_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top
// Pulse-distance infrared frame decoder with APB window registers.
// A frame word passes the input register and then the result register after the beat of its last bit.
// Throughput: one interval beat per cycle while result beats drain, set by the single classify stage.
// A stalled result beat holds the input register only once it is also full.
// Reset clears the frame state and loads the default windows.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top #(
    parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [irpd_pkg::INTERVAL_W-1:0] s_tdata,   // [15:0] edge_interval
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irpd_pkg::FRAME_W-1:0]    m_tdata,   // [31:0] frame_data
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irpd_pkg::APB_AW-1:0]     paddr,
    input  logic [irpd_pkg::APB_DW-1:0]     pwdata,
    output logic [irpd_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import irpd_pkg::*;

    irpd_cfg_t cfg;

    irpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpd_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- src/irpd_checker.sv -----
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks on the decoder's stream and register handshakes.
// ----------------------------------------------------------------------------
module irpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [irpd_pkg::FRAME_W-1:0] m_tdata,
    input logic                        pready
);

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A new result appears only once a taken input beat has passed the input register into the result register.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result beat without a preceding input beat");

    // The input side stalls only behind a blocked result beat.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind ir_pulse_distance_decoder_top irpd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
